/* design/bmp_pkg.sv */
// ----------------------------------------------------------------------------
// bmp_pkg: shared codes for the binomial-mod-prime-power block
// Status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package bmp_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int STATUS_W    = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_PRIME   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS = 2'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_K_GT_N  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_UNIT = 2'd2;

endpackage

/* design/bmp_mulmod.sv */
// ----------------------------------------------------------------------------
// bmp_mulmod: bit-serial modular multiplier
// Computes (a * b) mod m, one bit of b per cycle, MSB first. Needs a < m.
// ----------------------------------------------------------------------------
module bmp_mulmod #(
    parameter int MOD_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MOD_WIDTH-1:0] a,
    input  logic [MOD_WIDTH-1:0] b,
    input  logic [MOD_WIDTH-1:0] m,
    output logic                 done,
    output logic [MOD_WIDTH-1:0] product
);

    localparam int CW = $clog2(MOD_WIDTH + 1);

    logic [MOD_WIDTH-1:0] a_reg;
    logic [MOD_WIDTH-1:0] b_reg;
    logic [MOD_WIDTH-1:0] m_reg;
    logic [MOD_WIDTH-1:0] acc_reg;
    logic [MOD_WIDTH-1:0] acc_next;
    logic [CW-1:0]        cnt_reg;
    logic                 done_reg;

    logic [MOD_WIDTH:0] dbl;
    logic [MOD_WIDTH:0] dbl_red;
    logic [MOD_WIDTH:0] sum;
    logic [MOD_WIDTH:0] sum_red;

    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        sum     = dbl_red + (b_reg[MOD_WIDTH-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= {1'b0, m_reg}) ? sum - {1'b0, m_reg} : sum;
        acc_next = sum_red[MOD_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(MOD_WIDTH);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            m_reg   <= m;
            acc_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[MOD_WIDTH-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* design/bmp_divider.sv */
// ----------------------------------------------------------------------------
// bmp_divider: restoring divider
// One quotient bit per cycle; divisor must be nonzero.
// ----------------------------------------------------------------------------
module bmp_divider #(
    parameter int DIV_WIDTH = 32,
    parameter int MOD_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_WIDTH-1:0] dividend,
    input  logic [MOD_WIDTH-1:0] divisor,
    output logic                 done,
    output logic [DIV_WIDTH-1:0] quotient,
    output logic [MOD_WIDTH-1:0] remainder
);

    localparam int CW = $clog2(DIV_WIDTH + 1);

    logic [DIV_WIDTH-1:0] dvd_reg;
    logic [MOD_WIDTH-1:0] dsr_reg;
    logic [MOD_WIDTH-1:0] rem_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 done_reg;

    logic [MOD_WIDTH:0]   shifted;
    logic                 fits;
    logic [MOD_WIDTH:0]   diff;

    always_comb
    begin
        shifted = {rem_reg, dvd_reg[DIV_WIDTH-1]};
        fits    = (shifted >= {1'b0, dsr_reg});
        diff    = shifted - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(DIV_WIDTH);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? diff[MOD_WIDTH-1:0] : shifted[MOD_WIDTH-1:0];
            dvd_reg <= {dvd_reg[DIV_WIDTH-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

/* design/binomial_mod_prime_power.sv */
// ----------------------------------------------------------------------------
// binomial_mod_prime_power: C(n,k) modulo a configured prime power
// Sequencer over a shared bit-serial modular multiplier and a shared divider.
// ----------------------------------------------------------------------------
// channel   | direction | handshake               | payload
// command   | in        | start & !busy           | n_value, k_value
// result    | out       | done (one-cycle strobe) | residue, status
// config    | in        | cfg_valid & cfg_ready   | cfg_index, cfg_data
//
// One item runs the unit-part products over n, k and n-k, plus the Euclid
// and power steps; each product or division waits on the multiplier or the
// divider. Bad configuration and k > n are answered in the cycle after accept
// without leaving idle, so busy stays low for them; otherwise busy is high
// from accept until the result strobe. Reset sets prime and modulus to 2.
// Results cannot be held off.
// ----------------------------------------------------------------------------
module binomial_mod_prime_power
    import bmp_pkg::*;
#(
    parameter int ARG_WIDTH = 24,
    parameter int MOD_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [ARG_WIDTH-1:0]   n_value,
    input  logic [ARG_WIDTH-1:0]   k_value,
    output logic                   done,
    output logic [MOD_WIDTH-1:0]   residue,
    output logic [STATUS_W-1:0]    status,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [MOD_WIDTH-1:0]   cfg_data
);

    localparam int DW = (ARG_WIDTH > MOD_WIDTH) ? ARG_WIDTH : MOD_WIDTH;

    typedef enum logic [4:0] {
        S_IDLE, S_VINIT, S_VCHK, S_VWAIT, S_UINIT, S_UCHK, S_CPCHK, S_CPMUL,
        S_CPADV, S_UMUL, S_UDIV, S_DEN, S_DENW, S_ECHK, S_EDIV, S_EMUL,
        S_UW, S_BASE, S_PCHK, S_PMUL, S_PSQ, S_FIN
    } state_t;

    state_t state_reg;

    logic [MOD_WIDTH-1:0] prime_reg;
    logic [MOD_WIDTH-1:0] modulus_reg;

    logic [ARG_WIDTH-1:0] n_reg, k_reg, x_reg, v_reg, e_reg;
    logic [ARG_WIDTH:0]   j_reg;
    logic [1:0]           ph_reg;
    logic [MOD_WIDTH-1:0] un_reg, uk_reg, unk_reg, ur_reg, cp_reg;
    logic [MOD_WIDTH-1:0] jp_reg, jm_reg;
    logic [MOD_WIDTH-1:0] t_reg, nt_reg, r_reg, nr_reg, er_reg;
    logic [MOD_WIDTH-1:0] base_reg, pr_reg;

    logic                 done_reg;
    logic [MOD_WIDTH-1:0] residue_reg;
    logic [STATUS_W-1:0]  status_reg;

    logic                 mul_start_reg;
    logic [MOD_WIDTH-1:0] mul_a_reg, mul_b_reg;
    logic                 mul_done;
    logic [MOD_WIDTH-1:0] mul_prod;

    logic                 div_start_reg;
    logic [DW-1:0]        div_dvd_reg;
    logic [MOD_WIDTH-1:0] div_dsr_reg;
    logic                 div_done;
    logic [DW-1:0]        div_quo;
    logic [MOD_WIDTH-1:0] div_rem;

    logic [MOD_WIDTH-1:0] one_m;
    logic [ARG_WIDTH-1:0] x_sel;
    logic [ARG_WIDTH-1:0] x_sel_next;
    logic [ARG_WIDTH-1:0] quo_arg;
    logic [MOD_WIDTH:0]   jp_inc, jm_inc;
    logic [MOD_WIDTH-1:0] q_red;
    logic [MOD_WIDTH-1:0] sub_res;

    bmp_mulmod #(.MOD_WIDTH(MOD_WIDTH)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .m       (modulus_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    bmp_divider #(.DIV_WIDTH(DW), .MOD_WIDTH(MOD_WIDTH)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (div_dvd_reg),
        .divisor   (div_dsr_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        one_m   = (modulus_reg == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
        quo_arg = div_quo[ARG_WIDTH-1:0];
        jp_inc  = {1'b0, jp_reg} + 1'b1;
        jm_inc  = {1'b0, jm_reg} + 1'b1;
        // quotient equals m only when dividing m by one; reduce it to zero
        q_red   = (div_quo == DW'(modulus_reg)) ? '0 : div_quo[MOD_WIDTH-1:0];
        sub_res = (t_reg >= mul_prod) ? t_reg - mul_prod
                                      : t_reg + (modulus_reg - mul_prod);
        unique case (ph_reg)
            2'd0:    x_sel = n_reg;
            2'd1:    x_sel = k_reg;
            default: x_sel = n_reg - k_reg;
        endcase
        unique case (ph_reg)
            2'd0:    x_sel_next = k_reg;
            default: x_sel_next = n_reg - k_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg   <= MOD_WIDTH'(2);
            modulus_reg <= MOD_WIDTH'(2);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_PRIME)
            begin
                prime_reg <= cfg_data;
            end
            else if (cfg_index == REG_MODULUS)
            begin
                modulus_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            residue_reg   <= '0;
            status_reg    <= STATUS_OK;
        end
        else
        begin
            done_reg      <= 1'b0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        n_reg  <= n_value;
                        k_reg  <= k_value;
                        v_reg  <= '0;
                        ph_reg <= 2'd0;
                        if (prime_reg < MOD_WIDTH'(2) || modulus_reg == '0)
                        begin
                            done_reg    <= 1'b1;
                            residue_reg <= '0;
                            status_reg  <= STATUS_NO_UNIT;
                        end
                        else if (k_value > n_value)
                        begin
                            done_reg    <= 1'b1;
                            residue_reg <= '0;
                            status_reg  <= STATUS_K_GT_N;
                        end
                        else
                        begin
                            state_reg <= S_VINIT;
                        end
                    end
                end
                S_VINIT:
                begin
                    x_reg     <= x_sel;
                    state_reg <= S_VCHK;
                end
                S_VCHK:
                begin
                    if (x_reg == '0)
                    begin
                        state_reg <= S_UINIT;
                    end
                    else
                    begin
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= DW'(x_reg);
                        div_dsr_reg   <= prime_reg;
                        state_reg     <= S_VWAIT;
                    end
                end
                S_VWAIT:
                begin
                    if (div_done)
                    begin
                        x_reg     <= quo_arg;
                        v_reg     <= (ph_reg == 2'd0) ? v_reg + quo_arg : v_reg - quo_arg;
                        state_reg <= S_VCHK;
                    end
                end
                S_UINIT:
                begin
                    x_reg     <= x_sel;
                    ur_reg    <= one_m;
                    state_reg <= S_UCHK;
                end
                S_UCHK:
                begin
                    if (x_reg == '0)
                    begin
                        unique case (ph_reg)
                            2'd0:    un_reg  <= ur_reg;
                            2'd1:    uk_reg  <= ur_reg;
                            default: unk_reg <= ur_reg;
                        endcase
                        if (ph_reg == 2'd2)
                        begin
                            state_reg <= S_DEN;
                        end
                        else
                        begin
                            ph_reg    <= ph_reg + 1'b1;
                            x_reg     <= x_sel_next;
                            state_reg <= S_VCHK;
                        end
                    end
                    else
                    begin
                        cp_reg    <= one_m;
                        j_reg     <= (ARG_WIDTH+1)'(1);
                        jp_reg    <= MOD_WIDTH'(1);
                        jm_reg    <= one_m;
                        state_reg <= S_CPCHK;
                    end
                end
                S_CPCHK:
                begin
                    if (j_reg > {1'b0, x_reg})
                    begin
                        mul_start_reg <= 1'b1;
                        mul_a_reg     <= ur_reg;
                        mul_b_reg     <= cp_reg;
                        state_reg     <= S_UMUL;
                    end
                    else if (jp_reg != '0)
                    begin
                        mul_start_reg <= 1'b1;
                        mul_a_reg     <= cp_reg;
                        mul_b_reg     <= jm_reg;
                        state_reg     <= S_CPMUL;
                    end
                    else
                    begin
                        state_reg <= S_CPADV;
                    end
                end
                S_CPMUL:
                begin
                    if (mul_done)
                    begin
                        cp_reg    <= mul_prod;
                        state_reg <= S_CPADV;
                    end
                end
                S_CPADV:
                begin
                    // track j mod p and j mod m without dividing
                    j_reg     <= j_reg + 1'b1;
                    jp_reg    <= (jp_inc == {1'b0, prime_reg}) ? '0 : jp_inc[MOD_WIDTH-1:0];
                    jm_reg    <= (jm_inc == {1'b0, modulus_reg}) ? '0 : jm_inc[MOD_WIDTH-1:0];
                    state_reg <= S_CPCHK;
                end
                S_UMUL:
                begin
                    if (mul_done)
                    begin
                        ur_reg        <= mul_prod;
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= DW'(x_reg);
                        div_dsr_reg   <= prime_reg;
                        state_reg     <= S_UDIV;
                    end
                end
                S_UDIV:
                begin
                    if (div_done)
                    begin
                        x_reg     <= quo_arg;
                        state_reg <= S_UCHK;
                    end
                end
                S_DEN:
                begin
                    mul_start_reg <= 1'b1;
                    mul_a_reg     <= uk_reg;
                    mul_b_reg     <= unk_reg;
                    state_reg     <= S_DENW;
                end
                S_DENW:
                begin
                    if (mul_done)
                    begin
                        t_reg     <= '0;
                        nt_reg    <= one_m;
                        r_reg     <= modulus_reg;
                        nr_reg    <= mul_prod;
                        state_reg <= S_ECHK;
                    end
                end
                S_ECHK:
                begin
                    if (nr_reg == '0)
                    begin
                        if (r_reg == MOD_WIDTH'(1))
                        begin
                            mul_start_reg <= 1'b1;
                            mul_a_reg     <= un_reg;
                            mul_b_reg     <= t_reg;
                            state_reg     <= S_UW;
                        end
                        else
                        begin
                            done_reg    <= 1'b1;
                            residue_reg <= '0;
                            status_reg  <= STATUS_NO_UNIT;
                            state_reg   <= S_IDLE;
                        end
                    end
                    else
                    begin
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= DW'(r_reg);
                        div_dsr_reg   <= nr_reg;
                        state_reg     <= S_EDIV;
                    end
                end
                S_EDIV:
                begin
                    if (div_done)
                    begin
                        er_reg        <= div_rem;
                        mul_start_reg <= 1'b1;
                        mul_a_reg     <= q_red;
                        mul_b_reg     <= nt_reg;
                        state_reg     <= S_EMUL;
                    end
                end
                S_EMUL:
                begin
                    if (mul_done)
                    begin
                        t_reg     <= nt_reg;
                        nt_reg    <= sub_res;
                        r_reg     <= nr_reg;
                        nr_reg    <= er_reg;
                        state_reg <= S_ECHK;
                    end
                end
                S_UW:
                begin
                    if (mul_done)
                    begin
                        ur_reg        <= mul_prod;
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= DW'(prime_reg);
                        div_dsr_reg   <= modulus_reg;
                        state_reg     <= S_BASE;
                    end
                end
                S_BASE:
                begin
                    if (div_done)
                    begin
                        base_reg  <= div_rem;
                        pr_reg    <= one_m;
                        e_reg     <= v_reg;
                        state_reg <= S_PCHK;
                    end
                end
                S_PCHK:
                begin
                    mul_start_reg <= 1'b1;
                    if (e_reg == '0)
                    begin
                        mul_a_reg <= pr_reg;
                        mul_b_reg <= ur_reg;
                        state_reg <= S_FIN;
                    end
                    else if (e_reg[0])
                    begin
                        mul_a_reg <= pr_reg;
                        mul_b_reg <= base_reg;
                        state_reg <= S_PMUL;
                    end
                    else
                    begin
                        mul_a_reg <= base_reg;
                        mul_b_reg <= base_reg;
                        state_reg <= S_PSQ;
                    end
                end
                S_PMUL:
                begin
                    if (mul_done)
                    begin
                        pr_reg        <= mul_prod;
                        mul_start_reg <= 1'b1;
                        mul_a_reg     <= base_reg;
                        mul_b_reg     <= base_reg;
                        state_reg     <= S_PSQ;
                    end
                end
                S_PSQ:
                begin
                    if (mul_done)
                    begin
                        base_reg  <= mul_prod;
                        e_reg     <= e_reg >> 1;
                        state_reg <= S_PCHK;
                    end
                end
                S_FIN:
                begin
                    if (mul_done)
                    begin
                        done_reg    <= 1'b1;
                        residue_reg <= mul_prod;
                        status_reg  <= STATUS_OK;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign residue   = residue_reg;
    assign status    = status_reg;

endmodule

/* verif/bmp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_checker: scoreboard for the binomial-mod-prime-power block
// Watches the command, config and result channels. It predicts C(n,k) mod M
// from its own copy of the registers and compares each result beat in order.
// ----------------------------------------------------------------------------
module bmp_checker
    import bmp_pkg::*;
#(
    parameter int ARG_WIDTH = 24,
    parameter int MOD_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [ARG_WIDTH-1:0]   n_value,
    input  logic [ARG_WIDTH-1:0]   k_value,
    input  logic                   done,
    input  logic [MOD_WIDTH-1:0]   residue,
    input  logic [STATUS_W-1:0]    status,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [MOD_WIDTH-1:0]   cfg_data,
    output int                     fail_count,
    output int                     pending
);

    typedef bit [63:0] u64_t;

    typedef struct {
        logic [MOD_WIDTH-1:0] residue;
        logic [STATUS_W-1:0]  status;
    } binom_t;

    binom_t binom_q[$];
    u64_t   cur_prime;
    u64_t   cur_modulus;

    function automatic u64_t mulmod(u64_t a, u64_t b, u64_t m);
        return ((a % m) * (b % m)) % m;
    endfunction

    function automatic u64_t submod(u64_t a, u64_t b, u64_t m);
        return (a >= b) ? a - b : a + (m - b);
    endfunction

    function automatic u64_t powmod(u64_t base, u64_t e, u64_t m);
        u64_t r;
        r = 1 % m;
        base = base % m;
        while (e != 0)
        begin
            if (e[0])
                r = mulmod(r, base, m);
            base = mulmod(base, base, m);
            e = e >> 1;
        end
        return r;
    endfunction

    // exponent of p in x!
    function automatic u64_t legendre(u64_t x, u64_t p);
        u64_t v;
        v = 0;
        while (x != 0)
        begin
            x = x / p;
            v = v + x;
        end
        return v;
    endfunction

    function automatic u64_t fact_unit(u64_t x, u64_t p, u64_t m);
        u64_t r;
        u64_t f;
        r = 1 % m;
        while (x != 0)
        begin
            f = 1 % m;
            for (u64_t j = 1; j <= x; j++)
                if (j % p != 0)
                    f = mulmod(f, j % m, m);
            r = mulmod(r, f, m);
            x = x / p;
        end
        return r;
    endfunction

    function automatic binom_t predict_binom(u64_t n, u64_t k);
        binom_t b;
        u64_t   p;
        u64_t   m;
        u64_t   v;
        u64_t   den;
        u64_t   t;
        u64_t   nt;
        u64_t   r;
        u64_t   nr;
        u64_t   q;
        u64_t   tmp;
        p = cur_prime;
        m = cur_modulus;
        b.residue = '0;
        b.status  = STATUS_OK;
        if (p < 2 || m == 0)
        begin
            b.status = STATUS_NO_UNIT;
            return b;
        end
        if (k > n)
        begin
            b.status = STATUS_K_GT_N;
            return b;
        end
        v   = legendre(n, p) - legendre(k, p) - legendre(n - k, p);
        den = mulmod(fact_unit(k, p, m), fact_unit(n - k, p, m), m);
        // extended Euclid for the inverse of den
        t  = 0;
        nt = 1 % m;
        r  = m;
        nr = den % m;
        while (nr != 0)
        begin
            q   = r / nr;
            tmp = submod(t, mulmod(q % m, nt, m), m);
            t   = nt;
            nt  = tmp;
            tmp = r - q * nr;
            r   = nr;
            nr  = tmp;
        end
        if (r != 1)
        begin
            b.status = STATUS_NO_UNIT;
            return b;
        end
        b.residue = MOD_WIDTH'(mulmod(powmod(p, v, m),
                                      mulmod(fact_unit(n, p, m), t, m), m));
        return b;
    endfunction

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    assign pending = binom_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        binom_t got;
        binom_t want;
        if (!rst_n)
        begin
            cur_prime   <= 2;
            cur_modulus <= 2;
            fail_count  <= 0;
            binom_q.delete();
        end
        else
        begin
            if (done)
            begin
                got.residue = residue;
                got.status  = status;
                if (binom_q.size() == 0)
                    report($sformatf("unexpected result residue=%0d status=%0d",
                                     residue, status));
                else
                begin
                    want = binom_q.pop_front();
                    if (got.residue !== want.residue)
                        report($sformatf("residue %0d, want %0d", got.residue,
                                         want.residue));
                    if (got.status !== want.status)
                        report($sformatf("status %0d, want %0d", got.status,
                                         want.status));
                end
            end
            if (start && !busy)
                binom_q.push_back(predict_binom(u64_t'(n_value), u64_t'(k_value)));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_PRIME)
                    cur_prime <= u64_t'(cfg_data);
                else if (cfg_index == REG_MODULUS)
                    cur_modulus <= u64_t'(cfg_data);
            end
        end
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top-level bench for binomial_mod_prime_power
// Walks through prime/modulus settings, drives directed and random n,k
// commands with random gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
    import bmp_pkg::*;

    localparam int ARG_WIDTH = 24;
    localparam int MOD_WIDTH = 32;
    localparam int IDLE_LIMIT = 2000000;
    localparam int N_PHASES = 13;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [ARG_WIDTH-1:0]   n_value = '0;
    logic [ARG_WIDTH-1:0]   k_value = '0;
    logic                   done;
    logic [MOD_WIDTH-1:0]   residue;
    logic [STATUS_W-1:0]    status;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_PRIME;
    logic [MOD_WIDTH-1:0]   cfg_data = '0;
    int                     fail_count;
    int                     pending;
    int                     idle_cycles = 0;
    bit                     no_gaps;

    logic [MOD_WIDTH-1:0] prime_tab[N_PHASES] = '{
        32'd2, 32'd2, 32'd3, 32'd5, 32'd7, 32'd2, 32'd4294967291, 32'd3,
        32'd2, 32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF};
    logic [MOD_WIDTH-1:0] mod_tab[N_PHASES] = '{
        32'd2, 32'd1024, 32'd81, 32'd125, 32'd7, 32'd1, 32'd4294967291, 32'd10,
        32'd6, 32'd2, 32'd9, 32'd0, 32'hFFFF_FFFF};

    always #5 clk = ~clk;

    binomial_mod_prime_power #(.ARG_WIDTH(ARG_WIDTH), .MOD_WIDTH(MOD_WIDTH)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .n_value(n_value), .k_value(k_value), .done(done),
        .residue(residue), .status(status), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data));

    bmp_checker #(.ARG_WIDTH(ARG_WIDTH), .MOD_WIDTH(MOD_WIDTH)) u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .n_value(n_value), .k_value(k_value), .done(done),
        .residue(residue), .status(status), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending));

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // called at a falling edge; returns at a falling edge with start still high
    task automatic send_binom(input logic [ARG_WIDTH-1:0] n, input logic [ARG_WIDTH-1:0] k);
        bit taken;
        start   <= 1'b1;
        n_value <= n;
        k_value <= k;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
        end
        @(negedge clk);
    endtask

    task automatic idle_gap();
        int len;
        if (no_gaps)
            return;
        len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(20, 150);
        if (len == 0)
            return;
        start <= 1'b0;
        repeat (len) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [MOD_WIDTH-1:0] val);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = cfg_ready;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // drop start before the next edge so the last command is not taken again
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        logic [ARG_WIDTH-1:0] n;
        logic [ARG_WIDTH-1:0] k;
        bit bad_cfg;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                write_reg(REG_PRIME, prime_tab[ph]);
                write_reg(REG_MODULUS, mod_tab[ph]);
            end
            bad_cfg = (prime_tab[ph] < 2) || (mod_tab[ph] == 0);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (ph == 0)
            begin
                send_binom(0, 0);             idle_gap();
                send_binom(1, 0);             idle_gap();
                send_binom(1, 1);             idle_gap();
                send_binom(5, 2);             idle_gap();
                send_binom(0, 1);             idle_gap();
                send_binom(24'hFFFFFE, 24'hFFFFFF); idle_gap();
                send_binom(0, 24'hFFFFFF);    idle_gap();
                send_binom(10, 3);            idle_gap();
                send_binom(64, 32);           idle_gap();
                send_binom(200, 100);         idle_gap();
            end
            for (int i = 0; i < 8; i++)
            begin
                if (bad_cfg)
                begin
                    // answered at once, so the full argument range is cheap here
                    n = ARG_WIDTH'($urandom);
                    k = ARG_WIDTH'($urandom);
                    if (i == 0) n = '1;
                    if (i == 1) k = '1;
                end
                else if ($urandom_range(0, 5) == 0)
                begin
                    // k above n with wide arguments
                    n = ARG_WIDTH'($urandom_range(0, 24'hFFFFFE));
                    k = ARG_WIDTH'($urandom_range(n + 1, 24'hFFFFFF));
                end
                else
                begin
                    n = ARG_WIDTH'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 400)
                                                               : $urandom_range(0, 40));
                    k = ARG_WIDTH'($urandom_range(0, n));
                end
                send_binom(n, k);
                idle_gap();
            end
            drain();
        end

        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* binomial_mod_prime_power.f */
design/bmp_pkg.sv
design/bmp_mulmod.sv
design/bmp_divider.sv
design/binomial_mod_prime_power.sv
verif/bmp_checker.sv
verif/tb.sv
